// ===== rtl/core/lpmr_pkg.sv =====
// Package for the length-prefixed message ring.
// Types, codes and control/status bundles shared by the top level, lpmr_ctrl and lpmr_dp; no dependencies.
`default_nettype none
package lpmr_pkg;

    localparam int LEN_W   = 10;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 8;
    localparam int FILL_W  = 10;
    localparam int HIDX_W  = 3;

    typedef enum logic [1:0] {
        F_PUT_START = 2'd0,
        F_PUT_BYTE  = 2'd1,
        F_GET_START = 2'd2,
        F_GET_BYTE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_LARGE    = 3'd1,
        ST_LINE_FULL    = 3'd2,
        ST_EMPTY        = 3'd3,
        ST_READER_SMALL = 3'd4,
        ST_NO_XFER      = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DCHK,
        S_HB,
        S_HC,
        S_HUSE,
        S_HWR,
        S_GBYTE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              load;
        logic              set_st;
        t_status           st;
        logic              skip_read;
        logic              rd_next;
        logic              cap_lo;
        logic              cap_hi;
        logic              drop_step;
        logic              get_pop;
        logic              hdr_wr;
        logic              hdr_last;
        logic [HIDX_W-1:0] hdr_idx;
        logic              put_byte;
        logic              get_byte;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  put_open;
        logic  get_open;
        logic  len_big;
        logic  fits;
        logic  used_lt_need;
        logic  drop_on;
        logic  cnt_zero;
        logic  hdr_too_long;
        logic  out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/core/lpmr_req_if.sv =====
// Request channel interface: valid/ready plus one input item.
// Depends on nothing.
`default_nettype none
interface lpmr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [9:0] msg_len;
    logic [7:0] data_byte;
    logic [9:0] max_len;

    modport source (output valid, func, msg_len, data_byte, max_len, input ready);
    modport sink   (input valid, func, msg_len, data_byte, max_len, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lpmr_rsp_if.sv =====
// Response channel interface: valid/ready plus one result item.
// Depends on nothing.
`default_nettype none
interface lpmr_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] data_out;
    logic       last_byte;
    logic [9:0] len_out;
    logic [7:0] dropped;
    logic [7:0] block_count;
    logic [9:0] fill_bytes;

    modport source (output valid, status, data_out, last_byte, len_out, dropped,
                    block_count, fill_bytes, input ready);
    modport sink   (input valid, status, data_out, last_byte, len_out, dropped,
                    block_count, fill_bytes, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/length_prefixed_message_ring.sv =====
// Top level of the length-prefixed message ring.
// Depends on lpmr_pkg, lpmr_req_if, lpmr_rsp_if, lpmr_ctrl, lpmr_dp, lpmr_ram.
//
//  Channel   Dir  Beat                                   Handshake
//  i_req     in   func, msg_len, data_byte, max_len      valid/ready
//  o_rsp     out  status, data_out, last_byte, len_out,  valid/ready
//                 dropped, block_count, fill_bytes
//  i_cfg_*   in   drop_oldest (1 bit)                    write enable
//
// One beat in at a time. A get start reads up to 2 header bytes through the registered
// RAM port; a put start makes HEADER_BYTES header writes; a dropping put first enters a
// walk that reads the header of each dropped message.
// The single RAM port pair bounds everything. Reset is synchronous and clears
// pointers, counts and drop_oldest (to 1); ring RAM is not cleared. The result sits
// in an output register; a new beat is taken only when that register is empty or
// is being read at the same edge.
`default_nettype none
module length_prefixed_message_ring
    import lpmr_pkg::*;
#(
    parameter int RING_BYTES   = 1024,
    parameter int HEADER_BYTES = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_wr_en,
    input  wire logic  i_cfg_wr_data,
    lpmr_req_if.sink   i_req,
    lpmr_rsp_if.source o_rsp
);
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    lpmr_ctrl #(.HEADER_BYTES(HEADER_BYTES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lpmr_dp #(.RING_BYTES(RING_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_func        (i_req.func),
        .i_msg_len     (i_req.msg_len),
        .i_data_byte   (i_req.data_byte),
        .i_max_len     (i_req.max_len),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_rsp.valid),
        .i_ready       (o_rsp.ready),
        .o_status      (o_rsp.status),
        .o_data_out    (o_rsp.data_out),
        .o_last_byte   (o_rsp.last_byte),
        .o_len_out     (o_rsp.len_out),
        .o_dropped     (o_rsp.dropped),
        .o_block_count (o_rsp.block_count),
        .o_fill_bytes  (o_rsp.fill_bytes)
    );

    assign i_req.ready = in_ready;

    // one item in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("beat accepted while an item is in flight");

    // final-byte flag only on a good get byte
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.last_byte) |-> (o_rsp.status == ST_OK))
        else $error("last_byte with error status");

    // drops happen only on a put that went ahead or ran dry
    a_drop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.dropped != 8'd0)) |->
        (o_rsp.status == ST_OK || o_rsp.status == ST_TOO_LARGE))
        else $error("dropped count with unexpected status");

    // a dropping put never reads a message header on an empty ring
    a_drop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.drop_step |-> !stat.cnt_zero)
        else $error("drop step with no stored message");
endmodule
`default_nettype wire

// ===== rtl/core/lpmr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module lpmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/lpmr_ctrl.sv =====
// Sequencer for the message ring: decodes an item and steps the datapath.
// Depends on lpmr_pkg.
`default_nettype none
module lpmr_ctrl
    import lpmr_pkg::*;
#(
    parameter int HEADER_BYTES = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    localparam int KW = $clog2(HEADER_BYTES + 1);

    t_state          r_state, n_state;
    logic [KW-1:0]   r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        o_cmd      = '0;
        o_cmd.st   = ST_OK;
        o_cmd.hdr_idx = HIDX_W'(r_k);
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FIN;
                case (i_stat.func)
                    F_PUT_START: begin
                        if (i_stat.put_open) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_NO_XFER;
                        end else if (i_stat.len_big) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_TOO_LARGE;
                        end else if (i_stat.fits) begin
                            n_k     = '0;
                            n_state = S_HWR;
                        end else if (i_stat.used_lt_need) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_TOO_LARGE;
                        end else if (!i_stat.drop_on) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_LINE_FULL;
                        end else begin
                            o_cmd.skip_read = 1'b1;
                            n_state         = S_DCHK;
                        end
                    end
                    F_PUT_BYTE: begin
                        if (!i_stat.put_open) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_NO_XFER;
                        end else begin
                            o_cmd.put_byte = 1'b1;
                        end
                    end
                    F_GET_START: begin
                        if (i_stat.get_open) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_NO_XFER;
                        end else if (i_stat.cnt_zero) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_EMPTY;
                        end else begin
                            n_state = S_HB;
                        end
                    end
                    default: begin
                        if (!i_stat.get_open) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_NO_XFER;
                        end else begin
                            n_state = S_GBYTE;
                        end
                    end
                endcase
            end
            S_DCHK: begin
                if (i_stat.fits) begin
                    n_k     = '0;
                    n_state = S_HWR;
                end else if (i_stat.cnt_zero) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_TOO_LARGE;
                    n_state      = S_FIN;
                end else begin
                    n_state = S_HB;
                end
            end
            S_HB: begin
                o_cmd.cap_lo  = 1'b1;
                o_cmd.rd_next = 1'b1;
                n_state       = (HEADER_BYTES >= 2) ? S_HC : S_HUSE;
            end
            S_HC: begin
                o_cmd.cap_hi = 1'b1;
                n_state      = S_HUSE;
            end
            S_HUSE: begin
                if (i_stat.func == F_PUT_START) begin
                    o_cmd.drop_step = 1'b1;
                    n_state         = S_DCHK;
                end else if (i_stat.hdr_too_long) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_READER_SMALL;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.get_pop = 1'b1;
                    n_state       = S_FIN;
                end
            end
            S_HWR: begin
                o_cmd.hdr_wr = 1'b1;
                n_k          = r_k + 1'b1;
                if (r_k == KW'(HEADER_BYTES - 1)) begin
                    o_cmd.hdr_last = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_GBYTE: begin
                o_cmd.get_byte = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/lpmr_dp.sv =====
// Datapath for the message ring: pointers, counts, ring RAM and result register.
// Depends on lpmr_pkg and lpmr_ram.
`default_nettype none
module lpmr_dp
    import lpmr_pkg::*;
#(
    parameter int RING_BYTES   = 1024,
    parameter int HEADER_BYTES = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    input  wire logic [1:0]        i_func,
    input  wire logic [LEN_W-1:0]  i_msg_len,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic [LEN_W-1:0]  i_max_len,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [2:0]             o_status,
    output logic [BYTE_W-1:0]      o_data_out,
    output logic                   o_last_byte,
    output logic [LEN_W-1:0]       o_len_out,
    output logic [CNT_W-1:0]       o_dropped,
    output logic [CNT_W-1:0]       o_block_count,
    output logic [FILL_W-1:0]      o_fill_bytes
);
    localparam int PW   = $clog2(RING_BYTES);
    localparam int CNTW = PW + 1;
    localparam int AW   = ((PW > LEN_W) ? PW : LEN_W) + 2;

    // control state
    logic [PW-1:0]    r_head, n_head, r_tail, n_tail;
    logic [CNTW-1:0]  r_count, n_count;
    logic [LEN_W-1:0] r_put_left, n_put_left, r_get_left, n_get_left;
    logic             r_drop_on, r_out_valid;
    // item payload and result scratch
    t_func            r_func;
    logic [LEN_W-1:0] r_msg_len, r_max_len, r_hdr, r_lout;
    logic [BYTE_W-1:0] r_data_byte, r_dout;
    t_status          r_status;
    logic             r_last;
    logic [CNT_W-1:0] r_ndrop;

    logic [PW:0]      used_w, raw_room, room;
    logic [PW-1:0]    used;
    logic [AW-1:0]    need;
    logic             we;
    logic [PW-1:0]    raddr;
    logic [BYTE_W-1:0] wdata, rdata;
    logic [CNT_W-1:0] blk;

    function automatic logic [PW-1:0] f_wrap(input logic [AW-1:0] s);
        logic [AW-1:0] d;
        begin
            d = s - AW'(RING_BYTES);
            f_wrap = (s >= AW'(RING_BYTES)) ? PW'(d) : PW'(s);
        end
    endfunction

    assign used_w   = {1'b0, r_tail} - {1'b0, r_head}
                      + ((r_tail < r_head) ? (PW+1)'(RING_BYTES) : '0);
    assign used     = PW'(used_w);
    assign raw_room = (PW+1)'(RING_BYTES - 1) - {1'b0, used};
    assign room     = (raw_room < (PW+1)'(HEADER_BYTES)) ? '0
                      : raw_room - (PW+1)'(HEADER_BYTES);
    assign need     = AW'(r_msg_len) + AW'(HEADER_BYTES);

    always_comb begin
        o_stat.func         = r_func;
        o_stat.put_open     = (r_put_left != '0);
        o_stat.get_open     = (r_get_left != '0);
        o_stat.len_big      = (HEADER_BYTES < 2) && (r_msg_len[LEN_W-1:8] != '0);
        o_stat.fits         = (AW'(room) >= need);
        o_stat.used_lt_need = (AW'(used) < need);
        o_stat.drop_on      = r_drop_on;
        o_stat.cnt_zero     = (r_count == '0);
        o_stat.hdr_too_long = (r_hdr > r_max_len);
        o_stat.out_free     = !r_out_valid || i_ready;
    end

    // ring RAM
    assign raddr = i_cmd.rd_next ? f_wrap(AW'(r_head) + AW'(1)) : r_head;
    assign we    = i_cmd.hdr_wr || i_cmd.put_byte;
    always_comb begin
        if (i_cmd.put_byte) begin
            wdata = r_data_byte;
        end else if (i_cmd.hdr_idx == HIDX_W'(0)) begin
            wdata = r_msg_len[7:0];
        end else if (i_cmd.hdr_idx == HIDX_W'(1)) begin
            wdata = BYTE_W'(r_msg_len[LEN_W-1:8]);
        end else begin
            wdata = '0;
        end
    end

    lpmr_ram #(.WIDTH(BYTE_W), .DEPTH(RING_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_tail),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_put_left = r_put_left;
        n_get_left = r_get_left;
        if (i_cmd.skip_read) begin
            n_head     = f_wrap(AW'(r_head) + AW'(r_get_left));
            n_get_left = '0;
        end
        if (i_cmd.drop_step) begin
            n_head  = f_wrap(AW'(r_head) + AW'(HEADER_BYTES) + AW'(r_hdr));
            n_count = r_count - 1'b1;
        end
        if (i_cmd.get_pop) begin
            n_head     = f_wrap(AW'(r_head) + AW'(HEADER_BYTES));
            n_get_left = r_hdr;
            n_count    = r_count - 1'b1;
        end
        if (i_cmd.get_byte) begin
            n_head     = f_wrap(AW'(r_head) + AW'(1));
            n_get_left = r_get_left - 1'b1;
        end
        if (we) begin
            n_tail = f_wrap(AW'(r_tail) + AW'(1));
        end
        if (i_cmd.put_byte) begin
            n_put_left = r_put_left - 1'b1;
            if (r_put_left == LEN_W'(1)) begin
                n_count = r_count + 1'b1;
            end
        end
        if (i_cmd.hdr_last) begin
            n_put_left = r_msg_len;
            if (r_msg_len == '0) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_put_left  <= '0;
            r_get_left  <= '0;
            r_drop_on   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_put_left <= n_put_left;
            r_get_left <= n_get_left;
            if (i_cfg_wr_en) begin
                r_drop_on <= i_cfg_wr_data;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign blk = ({{(32-CNTW){1'b0}}, r_count} > 32'd255) ? {CNT_W{1'b1}} : CNT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= t_func'(i_func);
            r_msg_len   <= i_msg_len;
            r_data_byte <= i_data_byte;
            r_max_len   <= i_max_len;
            r_status    <= ST_OK;
            r_dout      <= '0;
            r_last      <= 1'b0;
            r_lout      <= '0;
            r_ndrop     <= '0;
        end
        if (i_cmd.set_st) begin
            r_status <= i_cmd.st;
        end
        if (i_cmd.cap_lo) begin
            r_hdr <= LEN_W'(rdata);
        end
        if (i_cmd.cap_hi) begin
            r_hdr[LEN_W-1:8] <= rdata[LEN_W-9:0];
        end
        if (i_cmd.drop_step && (r_ndrop != {CNT_W{1'b1}})) begin
            r_ndrop <= r_ndrop + 1'b1;
        end
        if (i_cmd.get_pop) begin
            r_lout <= r_hdr;
        end
        if (i_cmd.get_byte) begin
            r_dout <= rdata;
            r_last <= (r_get_left == LEN_W'(1));
        end
        if (i_cmd.emit) begin
            o_status      <= r_status;
            o_data_out    <= r_dout;
            o_last_byte   <= r_last;
            o_len_out     <= r_lout;
            o_dropped     <= r_ndrop;
            o_block_count <= blk;
            o_fill_bytes  <= FILL_W'(used);
        end
    end

    assign o_valid = r_out_valid;
endmodule
`default_nettype wire
